// ===== rtl/page_framebuffer_rasterizer_unit_macros.svh =====
// assertion macros for the page frame buffer rasterizer checker
// no dependencies; included by the checker file
`ifndef PAGE_FRAMEBUFFER_RASTERIZER_UNIT_MACROS_SVH
`define PAGE_FRAMEBUFFER_RASTERIZER_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PFR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pfr assertion failed");

// antecedent implies consequent in the next cycle
`define PFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pfr assertion failed");

`endif

// ===== rtl/pfr_pkg.sv =====
// types, constants and codes for the page frame buffer rasterizer
// no dependencies; used by pfr_store, pfr_raster, the top level and the checker
`timescale 1ns / 1ps
`default_nettype none

package pfr_pkg;

	localparam int SCREEN_WIDTH  = 84;
	localparam int SCREEN_HEIGHT = 48;
	localparam int STORE_BYTES   = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8);
	localparam int ADDR_W        = $clog2(STORE_BYTES);
	localparam int COORD_W       = 16;
	localparam int LERR_W        = 13;
	localparam int ERR_W         = 36;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [LERR_W-1:0]  lerr_t;
	typedef logic signed [ERR_W-1:0]   eerr_t;

	// command kinds
	typedef enum logic [2:0] {
		KIND_PIXEL   = 3'd0,
		KIND_LINE    = 3'd1,
		KIND_RECT    = 3'd2,
		KIND_ELLIPSE = 3'd3,
		KIND_CLEAR   = 3'd4,
		KIND_READ    = 3'd5
	} kind_t;

	// pixel write modes
	typedef enum logic [1:0] {
		MODE_CLR  = 2'd0,
		MODE_SET  = 2'd1,
		MODE_XOR  = 2'd2,
		MODE_KEEP = 2'd3
	} mode_t;

	// store operations
	typedef enum logic [1:0] {
		ST_PLOT  = 2'd0,
		ST_CLEAR = 2'd1,
		ST_READ  = 2'd2
	} st_op_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic signed [8:0] xs;
		logic signed [8:0] ys;
		logic signed [8:0] xe;
		logic signed [8:0] ye;
		logic [7:0]        rx;
		logic [7:0]        ry;
		logic [1:0]        mode;
		logic [8:0]        ridx;
	} cmd_t;

	typedef struct packed {
		st_op_t     op;
		coord_t     x;
		coord_t     y;
		mode_t      mode;
		logic [8:0] index;
	} st_req_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} st_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/pfr_if.sv =====
// command and result channel interfaces of the rasterizer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface pfr_cmd_if;
	logic              valid;
	logic              ready;
	logic [2:0]        kind;
	logic signed [8:0] x_start;
	logic signed [8:0] y_start;
	logic signed [8:0] x_end;
	logic signed [8:0] y_end;
	logic [7:0]        radius_x;
	logic [7:0]        radius_y;
	logic [1:0]        pixel_mode;
	logic [8:0]        read_index;

	modport source (output valid, kind, x_start, y_start, x_end, y_end, radius_x,
		radius_y, pixel_mode, read_index, input ready);
	modport sink (input valid, kind, x_start, y_start, x_end, y_end, radius_x,
		radius_y, pixel_mode, read_index, output ready);
endinterface

interface pfr_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic [2:0] done_kind;

	modport source (output valid, read_data, done_kind, input ready);
	modport sink (input valid, read_data, done_kind, output ready);
endinterface

`default_nettype wire

// ===== rtl/pfr_store.sv =====
// frame store memory with pixel read-modify-write, byte read and clear sweep
// depends on pfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module pfr_store
	import pfr_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    req_valid,
	input  wire st_req_t req,
	output logic         req_ready,
	output st_rsp_t      rsp
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RMW  = 4'b0010,
		S_READ = 4'b0100,
		S_CLR  = 4'b1000
	} st_state_t;

	st_state_t         state_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              clr_cmd_q;
	logic [ADDR_W-1:0] idx_q;
	logic [7:0]        mask_q;
	mode_t             mode_q;
	logic              rsp_valid_q;
	logic [7:0]        rsp_data_q;

	logic [7:0]        mem [STORE_BYTES];
	logic [7:0]        rdata_q;

	logic              in_range;
	logic [15:0]       row;
	logic [15:0]       idx_full;
	logic [ADDR_W-1:0] raddr;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [7:0]        wdata;
	logic [7:0]        modified;
	logic              read_ok;

	assign req_ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// pixel address and range
	always_comb begin
		in_range = (req.x >= 0) && (req.x < coord_t'(SCREEN_WIDTH)) &&
			(req.y >= 0) && (req.y < coord_t'(SCREEN_HEIGHT));
		row      = 16'(req.y >>> 3);
		idx_full = 16'(row * 16'(SCREEN_WIDTH)) + 16'(req.x);
		read_ok  = (32'(req.index) < 32'(STORE_BYTES));
		raddr    = (req.op == ST_READ) ? ADDR_W'(req.index) : idx_full[ADDR_W-1:0];
	end

	// bit update
	always_comb begin
		unique case (mode_q)
			MODE_CLR:  modified = rdata_q & ~mask_q;
			MODE_SET:  modified = rdata_q | mask_q;
			MODE_XOR:  modified = rdata_q ^ mask_q;
			MODE_KEEP: modified = rdata_q;
		endcase
	end

	// write port select
	always_comb begin
		we    = (state_q == S_CLR) || (state_q == S_RMW);
		waddr = (state_q == S_CLR) ? clr_addr_q : idx_q;
		wdata = (state_q == S_CLR) ? 8'h00 : modified;
	end

	// memory array
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_addr_q  <= '0;
			clr_cmd_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						unique case (req.op)
							ST_PLOT: begin
								if (in_range) begin
									state_q     <= S_RMW;
									rsp_valid_q <= 1'b0;
								end else begin
									rsp_valid_q <= 1'b1;
								end
							end
							ST_READ: begin
								if (read_ok) begin
									state_q     <= S_READ;
									rsp_valid_q <= 1'b0;
								end else begin
									rsp_valid_q <= 1'b1;
								end
							end
							ST_CLEAR: begin
								state_q     <= S_CLR;
								clr_addr_q  <= '0;
								clr_cmd_q   <= 1'b1;
								rsp_valid_q <= 1'b0;
							end
							default: rsp_valid_q <= 1'b1;
						endcase
					end else begin
						rsp_valid_q <= 1'b0;
					end
				end
				S_RMW: begin
					state_q     <= S_IDLE;
					rsp_valid_q <= 1'b1;
				end
				S_READ: begin
					state_q     <= S_IDLE;
					rsp_valid_q <= 1'b1;
				end
				S_CLR: begin
					if (clr_addr_q == ADDR_W'(STORE_BYTES - 1)) begin
						state_q     <= S_IDLE;
						rsp_valid_q <= clr_cmd_q;
						clr_cmd_q   <= 1'b0;
					end else begin
						clr_addr_q  <= clr_addr_q + ADDR_W'(1);
						rsp_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q     <= S_IDLE;
					rsp_valid_q <= 1'b0;
				end
			endcase
		end
	end

	// payload of the operation in flight
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			idx_q      <= idx_full[ADDR_W-1:0];
			mask_q     <= 8'(8'd1 << req.y[2:0]);
			mode_q     <= req.mode;
			rsp_data_q <= 8'h00;
		end else if (state_q == S_READ) begin
			rsp_data_q <= rdata_q;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pfr_raster.sv =====
// command sequencer: pixels, reads, clears, bresenham lines, rectangles and ellipses
// depends on pfr_pkg and pfr_if; drives pfr_store one operation at a time
`timescale 1ns / 1ps
`default_nettype none

module pfr_raster
	import pfr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	pfr_cmd_if.sink   cmd,
	pfr_res_if.source res,
	output logic      st_valid,
	output st_req_t   st_req,
	input  wire logic st_ready,
	input  st_rsp_t   st_rsp
);

	typedef enum logic [13:0] {
		R_IDLE  = 14'b00000000000001,
		R_START = 14'b00000000000010,
		R_REQ   = 14'b00000000000100,
		R_WAIT  = 14'b00000000001000,
		R_LINIT = 14'b00000000010000,
		R_LPLOT = 14'b00000000100000,
		R_LSTEP = 14'b00000001000000,
		R_EMUL  = 14'b00000010000000,
		R_EINIT = 14'b00000100000000,
		R_EERR  = 14'b00001000000000,
		R_EPLOT = 14'b00010000000000,
		R_ESTEP = 14'b00100000000000,
		R_ETIP  = 14'b01000000000000,
		R_FIN   = 14'b10000000000000
	} r_state_t;

	r_state_t   state_q;
	r_state_t   ret_q;
	cmd_t       cmd_q;
	st_req_t    req_q;
	logic [7:0] rdata_q;
	logic [1:0] seg_q;

	// line walker
	coord_t     lx0_q, ly0_q, lx1_q, ly1_q;
	lerr_t      ldx_q, ldy_q, lerr_q;
	logic       lsxn_q, lsyn_q;

	// ellipse walker
	logic [15:0] a2_q, b2_q;
	eerr_t      tx_q, ty_q, eerr_q;
	coord_t     edx_q, edy_q;
	logic [2:0] q_q;

	logic       res_valid_q;
	logic [7:0] res_data_q;
	logic [2:0] res_kind_q;

	// combinational helpers
	logic [1:0] seg_sel;
	coord_t     nx0, ny0, nx1, ny1;
	lerr_t      le2;
	logic       at_end;
	coord_t     xm, ym, qx, qy;
	eerr_t      e2, twob2, twoa2, eerr_n, tx_n, ty_n;
	logic       cx, cy, dec_y;
	coord_t     edy_n;
	logic signed [9:0]  twob_m1;
	logic signed [26:0] ty_prod;

	assign cmd.ready     = (state_q == R_IDLE) && st_ready;
	assign res.valid     = res_valid_q;
	assign res.read_data = res_data_q;
	assign res.done_kind = res_kind_q;
	assign st_valid      = (state_q == R_REQ);
	assign st_req        = req_q;

	// segment endpoints of a line or rectangle
	always_comb begin
		seg_sel = (state_q == R_START) ? 2'd0 : 2'(seg_q + 2'd1);
		nx0 = coord_t'(cmd_q.xs);
		ny0 = coord_t'(cmd_q.ys);
		nx1 = coord_t'(cmd_q.xe);
		ny1 = coord_t'(cmd_q.ye);
		if (kind_t'(cmd_q.kind) == KIND_RECT) begin
			unique case (seg_sel)
				2'd0: ny1 = coord_t'(cmd_q.ys);
				2'd1: nx0 = coord_t'(cmd_q.xe);
				2'd2: ny0 = coord_t'(cmd_q.ye);
				2'd3: nx1 = coord_t'(cmd_q.xs);
			endcase
		end
	end

	// line step terms
	always_comb begin
		le2    = lerr_q <<< 1;
		at_end = (lx0_q == lx1_q) && (ly0_q == ly1_q);
	end

	// ellipse quadrant point and step terms
	always_comb begin
		xm = coord_t'(cmd_q.xs);
		ym = coord_t'(cmd_q.ys);
		unique case (q_q[1:0])
			2'd0: begin qx = xm + edx_q; qy = ym + edy_q; end
			2'd1: begin qx = xm - edx_q; qy = ym + edy_q; end
			2'd2: begin qx = xm - edx_q; qy = ym - edy_q; end
			2'd3: begin qx = xm + edx_q; qy = ym - edy_q; end
		endcase
		e2      = eerr_q <<< 1;
		twob2   = eerr_t'({b2_q, 1'b0});
		twoa2   = eerr_t'({a2_q, 1'b0});
		cx      = (e2 < tx_q);
		cy      = (e2 > -ty_q);
		dec_y   = cy || !cx;
		eerr_n  = eerr_q + (cx ? (tx_q + twob2) : '0) - (cy ? (ty_q - twoa2) : '0);
		tx_n    = cx ? (tx_q + twob2) : tx_q;
		ty_n    = dec_y ? (ty_q - twoa2) : ty_q;
		edy_n   = dec_y ? (edy_q - coord_t'(1)) : edy_q;
		twob_m1 = $signed({1'b0, cmd_q.ry, 1'b0}) - 10'sd1;
		ty_prod = twob_m1 * $signed({1'b0, a2_q});
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= R_IDLE;
			ret_q       <= R_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res.ready && state_q != R_FIN) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				R_IDLE: begin
					if (cmd.valid && st_ready) begin
						state_q <= R_START;
					end
				end
				R_START: begin
					priority case (kind_t'(cmd_q.kind))
						KIND_PIXEL: begin
							ret_q   <= R_FIN;
							state_q <= R_REQ;
						end
						KIND_LINE, KIND_RECT: state_q <= R_LINIT;
						KIND_ELLIPSE: state_q <= R_EMUL;
						KIND_CLEAR, KIND_READ: begin
							ret_q   <= R_FIN;
							state_q <= R_REQ;
						end
						default: state_q <= R_FIN;
					endcase
				end
				R_REQ: begin
					if (st_ready) begin
						state_q <= R_WAIT;
					end
				end
				R_WAIT: begin
					if (st_rsp.valid) begin
						state_q <= ret_q;
					end
				end
				R_LINIT: state_q <= R_LPLOT;
				R_LPLOT: begin
					ret_q   <= R_LSTEP;
					state_q <= R_REQ;
				end
				R_LSTEP: begin
					if (!at_end) begin
						state_q <= R_LPLOT;
					end else if (kind_t'(cmd_q.kind) == KIND_RECT && seg_q != 2'd3) begin
						state_q <= R_LINIT;
					end else begin
						state_q <= R_FIN;
					end
				end
				R_EMUL:  state_q <= R_EINIT;
				R_EINIT: state_q <= R_EERR;
				R_EERR:  state_q <= R_EPLOT;
				R_EPLOT: begin
					if (q_q == 3'd4) begin
						state_q <= R_ESTEP;
					end else begin
						ret_q   <= R_EPLOT;
						state_q <= R_REQ;
					end
				end
				R_ESTEP: state_q <= (edy_n >= 0) ? R_EPLOT : R_ETIP;
				R_ETIP: begin
					if (q_q != 3'd0 || edx_q < coord_t'(cmd_q.rx)) begin
						ret_q   <= R_ETIP;
						state_q <= R_REQ;
					end else begin
						state_q <= R_FIN;
					end
				end
				R_FIN: begin
					if (!res_valid_q || res.ready) begin
						res_valid_q <= 1'b1;
						state_q     <= R_IDLE;
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			R_IDLE: begin
				cmd_q.kind <= cmd.kind;
				cmd_q.xs   <= cmd.x_start;
				cmd_q.ys   <= cmd.y_start;
				cmd_q.xe   <= cmd.x_end;
				cmd_q.ye   <= cmd.y_end;
				cmd_q.rx   <= cmd.radius_x;
				cmd_q.ry   <= cmd.radius_y;
				cmd_q.mode <= cmd.pixel_mode;
				cmd_q.ridx <= cmd.read_index;
				seg_q      <= 2'd0;
				rdata_q    <= 8'h00;
			end
			R_START: begin
				req_q.x     <= coord_t'(cmd_q.xs);
				req_q.y     <= coord_t'(cmd_q.ys);
				req_q.mode  <= mode_t'(cmd_q.mode);
				req_q.index <= cmd_q.ridx;
				req_q.op    <= (kind_t'(cmd_q.kind) == KIND_CLEAR) ? ST_CLEAR :
					(kind_t'(cmd_q.kind) == KIND_READ) ? ST_READ : ST_PLOT;
				lx0_q <= nx0;
				ly0_q <= ny0;
				lx1_q <= nx1;
				ly1_q <= ny1;
			end
			R_WAIT: begin
				if (st_rsp.valid) begin
					rdata_q <= st_rsp.data;
				end
			end
			R_LINIT: begin
				ldx_q  <= (lx1_q > lx0_q) ? lerr_t'(lx1_q - lx0_q) : lerr_t'(lx0_q - lx1_q);
				ldy_q  <= (ly1_q > ly0_q) ? lerr_t'(ly0_q - ly1_q) : lerr_t'(ly1_q - ly0_q);
				lerr_q <= ((lx1_q > lx0_q) ? lerr_t'(lx1_q - lx0_q) : lerr_t'(lx0_q - lx1_q)) +
					((ly1_q > ly0_q) ? lerr_t'(ly0_q - ly1_q) : lerr_t'(ly1_q - ly0_q));
				lsxn_q <= !(lx0_q < lx1_q);
				lsyn_q <= !(ly0_q < ly1_q);
			end
			R_LPLOT: begin
				req_q.op <= ST_PLOT;
				req_q.x  <= lx0_q;
				req_q.y  <= ly0_q;
			end
			R_LSTEP: begin
				if (!at_end) begin
					lerr_q <= lerr_q + ((le2 > ldy_q) ? ldy_q : lerr_t'(0)) +
						((le2 < ldx_q) ? ldx_q : lerr_t'(0));
					if (le2 > ldy_q) begin
						lx0_q <= lsxn_q ? (lx0_q - coord_t'(1)) : (lx0_q + coord_t'(1));
					end
					if (le2 < ldx_q) begin
						ly0_q <= lsyn_q ? (ly0_q - coord_t'(1)) : (ly0_q + coord_t'(1));
					end
				end else begin
					seg_q <= 2'(seg_q + 2'd1);
					lx0_q <= nx0;
					ly0_q <= ny0;
					lx1_q <= nx1;
					ly1_q <= ny1;
				end
			end
			R_EMUL: begin
				a2_q <= 16'(cmd_q.rx * cmd_q.rx);
				b2_q <= 16'(cmd_q.ry * cmd_q.ry);
			end
			R_EINIT: begin
				ty_q  <= eerr_t'(ty_prod);
				tx_q  <= eerr_t'({1'b0, b2_q});
				edx_q <= '0;
				edy_q <= coord_t'(cmd_q.ry);
				q_q   <= 3'd0;
			end
			R_EERR: eerr_q <= tx_q - ty_q;
			R_EPLOT: begin
				if (q_q != 3'd4) begin
					req_q.op <= ST_PLOT;
					req_q.x  <= qx;
					req_q.y  <= qy;
					q_q      <= 3'(q_q + 3'd1);
				end
			end
			R_ESTEP: begin
				eerr_q <= eerr_n;
				tx_q   <= tx_n;
				ty_q   <= ty_n;
				edx_q  <= cx ? (edx_q + coord_t'(1)) : edx_q;
				edy_q  <= edy_n;
				q_q    <= 3'd0;
			end
			R_ETIP: begin
				req_q.op <= ST_PLOT;
				req_q.y  <= ym;
				if (q_q == 3'd0) begin
					if (edx_q < coord_t'(cmd_q.rx)) begin
						edx_q   <= edx_q + coord_t'(1);
						req_q.x <= xm + edx_q + coord_t'(1);
						q_q     <= 3'd1;
					end
				end else begin
					req_q.x <= xm - edx_q;
					q_q     <= 3'd0;
				end
			end
			R_FIN: begin
				if (!res_valid_q || res.ready) begin
					res_kind_q <= cmd_q.kind;
					res_data_q <= (kind_t'(cmd_q.kind) == KIND_READ) ? rdata_q : 8'h00;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/page_framebuffer_rasterizer_unit.sv =====
// commands: pixel, read and clear are one store operation each; a line plots its pixels one by one;
// a rectangle is four lines; an ellipse plots four quadrant points per step
// throughput: one command at a time; a new command is taken only when the sequencer is idle and the store is ready
// reset: after arst_n the store runs a clearing pass over all 504 bytes, commands wait for it
// top level: frame store plus command sequencer; depends on pfr_pkg, pfr_if,
// pfr_store and pfr_raster
`timescale 1ns / 1ps
`default_nettype none

module page_framebuffer_rasterizer_unit
	import pfr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	pfr_cmd_if.sink   cmd,
	pfr_res_if.source res
);

	logic    st_valid;
	logic    st_ready;
	st_req_t st_req;
	st_rsp_t st_rsp;

	// command sequencer
	pfr_raster u_raster (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.res      (res),
		.st_valid (st_valid),
		.st_req   (st_req),
		.st_ready (st_ready),
		.st_rsp   (st_rsp)
	);

	// frame store
	pfr_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (st_valid),
		.req       (st_req),
		.req_ready (st_ready),
		.rsp       (st_rsp)
	);

endmodule

`default_nettype wire

// ===== rtl/pfr_checker.sv =====
// port-level checks of the rasterizer, bound to the top level
// depends on pfr_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "page_framebuffer_rasterizer_unit_macros.svh"

module pfr_checker
	import pfr_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       cmd_valid,
	input wire logic       cmd_ready,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic [7:0] read_data,
	input wire logic [2:0] done_kind
);

	// result held while stalled
	`PFR_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)
	`PFR_ASSERT_NEXT(a_res_stable, clk, arst_n, res_valid && !res_ready, $stable(read_data) && $stable(done_kind))
	// one command at a time
	`PFR_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, cmd_valid && cmd_ready, !cmd_ready)
	// only reads return data
	`PFR_ASSERT_SAME(a_data_only_read, clk, arst_n, res_valid && (done_kind != KIND_READ), read_data == 8'h00)

endmodule

bind page_framebuffer_rasterizer_unit pfr_checker u_pfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.read_data (res.read_data),
	.done_kind (res.done_kind)
);

`default_nettype wire
